// ===== src/descriptor_table_allocator_macros.svh =====
// Assertion macros for the descriptor table allocator.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DESCRIPTOR_TABLE_ALLOCATOR_MACROS_SVH
`define DESCRIPTOR_TABLE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define DTA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define DTA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dta_pkg.sv =====
// Shared types and constants for the descriptor table allocator.
// No dependencies; imported by every module of the block but dta_ram.
`timescale 1ns / 1ps

package dta_pkg;

    // Bitmap word geometry
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    // Fixed field widths of the ports
    localparam int FD_W       = 10;
    localparam int HANDLE_W   = 16;
    localparam int TOTAL_W    = 11;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    // Reset value of the lowest usable descriptor and of the search hint
    localparam logic [FD_W-1:0] LOW_FD_RESET = 10'd3;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 3'd0,
        OP_CLOSE  = 3'd1,
        OP_DUP    = 3'd2,
        OP_DUP2   = 3'd3,
        OP_GET    = 3'd4,
        OP_ISOPEN = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_BADF  = 2'd1,
        ST_FULL  = 2'd2,
        ST_INVAL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_FD,
        S_CHK_FD,
        S_RD_TGT,
        S_INST_TGT,
        S_SCAN_START,
        S_SCAN,
        S_DONE
    } state_t;

    // Answer of the free-bit search over one bitmap word
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } find_res_t;

endpackage

// ===== src/dta_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module dta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dta_find.sv =====
// Lowest-free-bit search over one 64-bit bitmap word, bounded below by a
// descriptor and above by the table size. Depends on dta_pkg.
`timescale 1ns / 1ps

module dta_find
    import dta_pkg::*;
#(
    parameter int DESCRIPTORS = 1024
) (
    input  logic [WORD_BITS-1:0] used_word,
    input  logic [(((DESCRIPTORS + WORD_BITS - 1) / WORD_BITS) > 1 ?
                   $clog2((DESCRIPTORS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] row,
    input  logic [(((DESCRIPTORS + WORD_BITS - 1) / WORD_BITS) > 1 ?
                   $clog2((DESCRIPTORS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] lb_row,
    input  logic [BIT_W-1:0]     lb_bit,
    output find_res_t            res
);

    localparam int WORDS     = (DESCRIPTORS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TAIL_BITS = DESCRIPTORS - (WORDS - 1) * WORD_BITS;
    localparam logic [WORD_W-1:0]    LAST_ROW  = WORD_W'(WORDS - 1);
    localparam logic [WORD_BITS-1:0] ONE_BIT   = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] TAIL_MASK = (TAIL_BITS == WORD_BITS) ? '1 :
                                                 ((ONE_BIT << TAIL_BITS) - ONE_BIT);

    logic [WORD_BITS-1:0] free;
    logic [WORD_BITS-1:0] lowest;
    logic [BIT_W-1:0]     idx;

    // Mask the free bits to the searched range
    always_comb begin
        free = ~used_word;
        if (row < lb_row) begin
            free = '0;
        end else if (row == lb_row) begin
            free = free & ({WORD_BITS{1'b1}} << lb_bit);
        end
        if (row == LAST_ROW) begin
            free = free & TAIL_MASK;
        end
    end

    // Isolate the lowest free bit and encode its position
    assign lowest = free & (~free + ONE_BIT);

    always_comb begin
        idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (lowest[j]) begin
                idx = idx | BIT_W'(j);
            end
        end
    end

    assign res.found = |free;
    assign res.idx   = idx;

endmodule

// ===== src/descriptor_table_allocator.sv =====
// Top level of the descriptor table allocator: sequencer, bitmap and handle
// stores. Depends on dta_pkg, dta_ram, dta_find and the assertion macros.
`timescale 1ns / 1ps
`include "descriptor_table_allocator_macros.svh"

// Descriptor table allocator. Each request carries one operation (alloc,
// close, dup, dup2, get, isopen) and returns one result with a status and
// the open count after the operation. One request is worked at a time; the
// block raises s_ready again once the previous result sits in the output
// register. Alloc and dup run a search that reads the used bitmap one
// 64-bit word per cycle through the bitmap memory's single read port. Alloc
// starts at the word of the lowest usable descriptor and dup at the word of
// the search hint; a dup whose search wraps around goes back through the
// scan start state and scans again from the word of the lowest usable
// descriptor. The used bitmap comes out of reset empty through one valid
// bit per word, so no clearing pass is needed. The user writes
// lowest_usable_fd through cfg_wen/cfg_wdata only while the block is idle;
// the block itself does not enforce this.
module descriptor_table_allocator
    import dta_pkg::*;
#(
    parameter int DESCRIPTORS = 1024,
    parameter int HANDLE_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wen,
    input  logic [FD_W-1:0]     cfg_wdata,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [FD_W-1:0]     s_fd,
    input  logic [FD_W-1:0]     s_target_fd,
    input  logic [HANDLE_W-1:0] s_file_handle,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [FD_W-1:0]     m_result_fd,
    output logic [HANDLE_W-1:0] m_handle_out,
    output logic                m_is_open,
    output logic [TOTAL_W-1:0]  m_open_total
);

    localparam int WORDS  = (DESCRIPTORS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ROWS   = 2 ** WORD_W;
    localparam int DW     = BIT_W + WORD_W;
    localparam int CW     = (DW + 1 > TOTAL_W) ? DW + 1 : TOTAL_W;
    localparam int CNT_W  = $clog2(DESCRIPTORS + 1);
    localparam logic [WORD_W-1:0]    LAST_ROW = WORD_W'(WORDS - 1);
    localparam logic [CW-1:0]        DESC_CW  = CW'(DESCRIPTORS);
    localparam logic [CNT_W-1:0]     DESC_CNT = CNT_W'(DESCRIPTORS);
    localparam logic [WORD_BITS-1:0] ONE_BIT  = WORD_BITS'(1);

    // Control and configuration registers
    state_t               state_reg, state_next;
    logic [FD_W-1:0]      low_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CW-1:0]        hint_reg, hint_next;
    logic [ROWS-1:0]      vld_reg, vld_next;
    logic                 m_valid_reg, m_valid_next;

    // Request and working registers
    op_t                  op_reg;
    logic [FD_W-1:0]      fd_reg, tgt_reg;
    logic [HANDLE_BITS-1:0] fh_reg, hnd_reg, hnd_next;
    logic [CW-1:0]        lb_reg, lb_next;
    logic [WORD_W-1:0]    row_reg, row_next;
    logic                 wrap_reg, wrap_next;
    logic                 row_ok_reg;

    // Pending result
    status_t              status_reg, status_next;
    logic [FD_W-1:0]      rfd_reg, rfd_next;
    logic [HANDLE_BITS-1:0] hout_reg, hout_next;
    logic                 isop_reg, isop_next;

    // Output register
    status_t              m_status_reg;
    logic [FD_W-1:0]      m_rfd_reg;
    logic [HANDLE_W-1:0]  m_hout_reg;
    logic                 m_isop_reg;
    logic [TOTAL_W-1:0]   m_total_reg;

    // Memory ports
    logic                   bm_we;
    logic [WORD_W-1:0]      bm_waddr, bm_raddr;
    logic [WORD_BITS-1:0]   bm_wdata, bm_rdata, bm_word;
    logic                   hs_we;
    logic [DW-1:0]          hs_waddr;
    logic [HANDLE_BITS-1:0] hs_wdata, hs_rdata;

    // Derived operands
    logic [31:0]          fh_wide, hout_wide, count_wide;
    logic [CW-1:0]        fd_ext, tgt_ext, low_ext, start_fd, found_ext;
    logic [WORD_W-1:0]    fd_row, tgt_row;
    logic [BIT_W-1:0]     fd_bit, tgt_bit;
    logic [DW-1:0]        fd_addr, tgt_addr, found_addr;
    logic                 fd_in_tab, fd_usable, fd_used, tgt_usable, tgt_used;
    logic                 low_in_tab, hint_usable, handle_nz;
    logic                 out_free;

    // Decode and scan decisions
    status_t              chk_status;
    logic                 chk_scan, chk_tgt;
    find_res_t            fr;
    logic                 scan_last, scan_rewind, scan_full;

    // Bitmap store, one row per 64 descriptors
    dta_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROWS)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // Handle store, read at the request's descriptor
    dta_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (2 ** DW)
    ) u_handles (
        .aclk  (aclk),
        .we    (hs_we),
        .waddr (hs_waddr),
        .wdata (hs_wdata),
        .raddr (fd_addr),
        .rdata (hs_rdata)
    );

    // Shared free-bit search unit
    dta_find #(
        .DESCRIPTORS (DESCRIPTORS)
    ) u_find (
        .used_word (bm_word),
        .row       (row_reg),
        .lb_row    (lb_reg[BIT_W +: WORD_W]),
        .lb_bit    (lb_reg[BIT_W-1:0]),
        .res       (fr)
    );

    // Operand decode
    assign fh_wide    = 32'(s_file_handle);
    assign fd_ext     = CW'(fd_reg);
    assign tgt_ext    = CW'(tgt_reg);
    assign low_ext    = CW'(low_reg);
    assign fd_row     = fd_ext[BIT_W +: WORD_W];
    assign fd_bit     = fd_ext[BIT_W-1:0];
    assign fd_addr    = fd_ext[DW-1:0];
    assign tgt_row    = tgt_ext[BIT_W +: WORD_W];
    assign tgt_bit    = tgt_ext[BIT_W-1:0];
    assign tgt_addr   = tgt_ext[DW-1:0];
    assign bm_word    = row_ok_reg ? bm_rdata : '0;
    assign fd_in_tab  = fd_ext < DESC_CW;
    assign fd_usable  = fd_in_tab && (fd_ext >= low_ext);
    assign fd_used    = fd_in_tab && bm_word[fd_bit];
    assign tgt_usable = (tgt_ext < DESC_CW) && (tgt_ext >= low_ext);
    assign tgt_used   = bm_word[tgt_bit];
    assign low_in_tab = low_ext < DESC_CW;
    assign hint_usable = (hint_reg < DESC_CW) && (hint_reg >= low_ext);
    assign start_fd   = hint_usable ? hint_reg : low_ext;
    assign handle_nz  = |hs_rdata;
    assign found_addr = {row_reg, fr.idx};
    assign found_ext  = CW'(found_addr);
    assign out_free   = !m_valid_reg || m_ready;

    // Judge the request once the descriptor's row and handle are read
    always_comb begin
        chk_status = ST_OK;
        chk_scan   = 1'b0;
        chk_tgt    = 1'b0;
        case (op_reg)
            OP_ALLOC: begin
                if (fh_reg == '0) begin
                    chk_status = ST_INVAL;
                end else if (count_reg >= DESC_CNT || !low_in_tab) begin
                    chk_status = ST_FULL;
                end else begin
                    chk_scan = 1'b1;
                end
            end
            OP_CLOSE: begin
                if (!fd_used || !handle_nz) begin
                    chk_status = ST_BADF;
                end
            end
            OP_DUP: begin
                if (!fd_usable || !fd_used || !handle_nz) begin
                    chk_status = ST_BADF;
                end else begin
                    chk_scan = 1'b1;
                end
            end
            OP_DUP2: begin
                if (!fd_usable || !tgt_usable) begin
                    chk_status = ST_BADF;
                end else if (fd_reg == tgt_reg) begin
                    chk_status = ST_INVAL;
                end else if (!fd_used) begin
                    chk_status = ST_BADF;
                end else begin
                    chk_tgt = 1'b1;
                end
            end
            OP_GET: begin
                if (!fd_usable || !fd_used) begin
                    chk_status = ST_BADF;
                end
            end
            OP_ISOPEN: begin
                chk_status = ST_OK;
            end
            default: begin
                chk_status = ST_INVAL;
            end
        endcase
    end

    // Scan outcome for the current word
    assign scan_last   = row_reg == LAST_ROW;
    assign scan_rewind = !fr.found && scan_last && (op_reg == OP_DUP) && !wrap_reg &&
                         (lb_reg != low_ext);
    assign scan_full   = !fr.found && scan_last && !scan_rewind;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_RD_FD;
                end
            end
            S_RD_FD: begin
                state_next = S_CHK_FD;
            end
            S_CHK_FD: begin
                if (chk_scan) begin
                    state_next = S_SCAN_START;
                end else if (chk_tgt) begin
                    state_next = S_RD_TGT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RD_TGT: begin
                state_next = S_INST_TGT;
            end
            S_INST_TGT: begin
                state_next = S_DONE;
            end
            S_SCAN_START: begin
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (fr.found || scan_full) begin
                    state_next = S_DONE;
                end else if (scan_rewind) begin
                    state_next = S_SCAN_START;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory controls, table state and pending result
    always_comb begin
        bm_we       = 1'b0;
        bm_waddr    = row_reg;
        bm_wdata    = bm_word;
        bm_raddr    = row_reg;
        hs_we       = 1'b0;
        hs_waddr    = tgt_addr;
        hs_wdata    = hnd_reg;
        count_next  = count_reg;
        hint_next   = hint_reg;
        lb_next     = lb_reg;
        row_next    = row_reg;
        wrap_next   = wrap_reg;
        hnd_next    = hnd_reg;
        status_next = status_reg;
        rfd_next    = rfd_reg;
        hout_next   = hout_reg;
        isop_next   = isop_reg;
        case (state_reg)
            S_RD_FD: begin
                bm_raddr = fd_row;
            end
            S_CHK_FD: begin
                status_next = chk_status;
                rfd_next    = '0;
                hout_next   = '0;
                isop_next   = 1'b0;
                hnd_next    = (op_reg == OP_ALLOC) ? fh_reg : hs_rdata;
                wrap_next   = 1'b0;
                lb_next     = (op_reg == OP_ALLOC) ? low_ext : start_fd;
                row_next    = lb_next[BIT_W +: WORD_W];
                if (chk_status == ST_OK && !chk_scan && !chk_tgt) begin
                    case (op_reg)
                        OP_CLOSE: begin
                            // release the descriptor and pull the hint down
                            bm_we    = 1'b1;
                            bm_waddr = fd_row;
                            bm_wdata = bm_word & ~(ONE_BIT << fd_bit);
                            if (count_reg != '0) begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            if (fd_ext < hint_reg) begin
                                hint_next = fd_ext;
                            end
                        end
                        OP_GET: begin
                            hout_next = hs_rdata;
                        end
                        OP_ISOPEN: begin
                            isop_next = fd_usable && fd_used;
                        end
                        default: begin
                            isop_next = 1'b0;
                        end
                    endcase
                end
            end
            S_RD_TGT: begin
                bm_raddr = tgt_row;
            end
            S_INST_TGT: begin
                // close an open target in place, then install the copy
                bm_we    = 1'b1;
                bm_waddr = tgt_row;
                bm_wdata = bm_word | (ONE_BIT << tgt_bit);
                hs_we    = 1'b1;
                hs_waddr = tgt_addr;
                hs_wdata = hnd_reg;
                if (tgt_used) begin
                    if (tgt_ext < hint_reg) begin
                        hint_next = tgt_ext;
                    end
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
                status_next = ST_OK;
                rfd_next    = tgt_reg;
            end
            S_SCAN: begin
                bm_raddr = row_reg + WORD_W'(1);
                if (fr.found) begin
                    bm_we       = 1'b1;
                    bm_waddr    = row_reg;
                    bm_wdata    = bm_word | (ONE_BIT << fr.idx);
                    hs_we       = 1'b1;
                    hs_waddr    = found_addr;
                    hs_wdata    = hnd_reg;
                    count_next  = count_reg + CNT_W'(1);
                    hint_next   = found_ext + CW'(1);
                    status_next = ST_OK;
                    rfd_next    = found_ext[FD_W-1:0];
                end else if (scan_rewind) begin
                    lb_next   = low_ext;
                    row_next  = low_ext[BIT_W +: WORD_W];
                    wrap_next = 1'b1;
                end else if (scan_full) begin
                    status_next = ST_FULL;
                end else begin
                    row_next = row_reg + WORD_W'(1);
                end
            end
            default: begin
                bm_we = 1'b0;
            end
        endcase
    end

    // Row valid bits: a row never written reads as all free
    always_comb begin
        vld_next = vld_reg;
        if (bm_we) begin
            vld_next[bm_waddr] = 1'b1;
        end
    end

    // Output handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (state_reg == S_DONE && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign s_ready    = state_reg == S_IDLE;
    assign hout_wide  = 32'(hout_reg);
    assign count_wide = 32'(count_reg);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            low_reg     <= LOW_FD_RESET;
            count_reg   <= '0;
            hint_reg    <= CW'(LOW_FD_RESET);
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            hint_reg    <= hint_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                low_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= op_t'(s_operation);
            fd_reg  <= s_fd;
            tgt_reg <= s_target_fd;
            fh_reg  <= fh_wide[HANDLE_BITS-1:0];
        end
        row_ok_reg  <= vld_reg[bm_raddr];
        hnd_reg     <= hnd_next;
        lb_reg      <= lb_next;
        row_reg     <= row_next;
        wrap_reg    <= wrap_next;
        status_reg  <= status_next;
        rfd_reg     <= rfd_next;
        hout_reg    <= hout_next;
        isop_reg    <= isop_next;
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= status_reg;
            m_rfd_reg    <= rfd_reg;
            m_hout_reg   <= hout_wide[HANDLE_W-1:0];
            m_isop_reg   <= isop_reg;
            m_total_reg  <= count_wide[TOTAL_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_result_fd  = m_rfd_reg;
    assign m_handle_out = m_hout_reg;
    assign m_is_open    = m_isop_reg;
    assign m_open_total = m_total_reg;

    // Checks
    `DTA_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DESC_CNT, "open count above table size")
    `DTA_ASSERT_IMP(a_error_zero, m_valid_reg && m_status_reg != ST_OK,
        m_rfd_reg == '0 && m_hout_reg == '0 && !m_isop_reg, "error result carries data")
    `DTA_ASSERT_IMP(a_scan_row, state_reg == S_SCAN, row_reg <= LAST_ROW, "scan past last row")
    `DTA_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")

endmodule

// ===== dv/descriptor_table_checker.sv =====
// Request/result checker for the descriptor table allocator testbench.
// Depends on dta_pkg; keeps its own copy of the table and compares each result.
`timescale 1ns / 1ps

module descriptor_table_checker
    import dta_pkg::*;
#(
    parameter int DESCRIPTORS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic [FD_W-1:0]     cfg_wdata,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [FD_W-1:0]     s_fd,
    input  logic [FD_W-1:0]     s_target_fd,
    input  logic [HANDLE_W-1:0] s_file_handle,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [FD_W-1:0]     m_result_fd,
    input  logic [HANDLE_W-1:0] m_handle_out,
    input  logic                m_is_open,
    input  logic [TOTAL_W-1:0]  m_open_total,
    output int                  fail_count,
    output int                  pending,
    output int                  checked
);

    typedef struct packed {
        status_t             status;
        logic [FD_W-1:0]     fd;
        logic [HANDLE_W-1:0] handle;
        logic                is_open;
        logic [TOTAL_W-1:0]  total;
    } table_answer_t;

    // Shadow copy of the descriptor table
    bit                  fd_in_use [DESCRIPTORS];
    logic [HANDLE_W-1:0] fd_handle [DESCRIPTORS];
    int                  shadow_open;
    int                  next_hint;
    int                  low_fd;

    table_answer_t answers_due [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    function automatic bit in_window(int d);
        return d >= low_fd && d < DESCRIPTORS;
    endfunction

    function automatic void free_fd(int d);
        fd_handle[d] = '0;
        fd_in_use[d] = 1'b0;
        if (shadow_open > 0) shadow_open--;
        if (d < next_hint) next_hint = d;
    endfunction

    function automatic void take_fd(int d, logic [HANDLE_W-1:0] h);
        fd_in_use[d] = 1'b1;
        fd_handle[d] = h;
        shadow_open++;
    endfunction

    // Apply one request to the shadow table and return the answer it must give
    function automatic table_answer_t predict_table_op(logic [OP_W-1:0] op,
                                                       logic [FD_W-1:0] fd,
                                                       logic [FD_W-1:0] tgt,
                                                       logic [HANDLE_W-1:0] fh);
        table_answer_t a;
        int d;
        int i;
        a = '0;
        a.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (fh == '0) begin
                    a.status = ST_INVAL;
                end else begin
                    a.status = ST_FULL;
                    if (shadow_open < DESCRIPTORS) begin
                        for (d = low_fd; d < DESCRIPTORS; d++) begin
                            if (!fd_in_use[d]) begin
                                take_fd(d, fh);
                                next_hint = d + 1;
                                a.fd = FD_W'(d);
                                a.status = ST_OK;
                                break;
                            end
                        end
                    end
                end
            end
            OP_CLOSE: begin
                if (!fd_in_use[fd] || fd_handle[fd] == '0) a.status = ST_BADF;
                else free_fd(int'(fd));
            end
            OP_DUP: begin
                if (!in_window(int'(fd)) || !fd_in_use[fd] || fd_handle[fd] == '0) begin
                    a.status = ST_BADF;
                end else begin
                    // circular search from the hint, wrapping at the lowest usable fd
                    a.status = ST_FULL;
                    d = next_hint;
                    for (i = 0; i < DESCRIPTORS; i++) begin
                        if (!in_window(d)) d = low_fd;
                        if (!fd_in_use[d]) begin
                            take_fd(d, fd_handle[fd]);
                            next_hint = d + 1;
                            a.fd = FD_W'(d);
                            a.status = ST_OK;
                            break;
                        end
                        d++;
                    end
                end
            end
            OP_DUP2: begin
                if (!in_window(int'(fd)) || !in_window(int'(tgt))) begin
                    a.status = ST_BADF;
                end else if (fd == tgt) begin
                    a.status = ST_INVAL;
                end else if (!fd_in_use[fd]) begin
                    a.status = ST_BADF;
                end else begin
                    // close an open target first, then install the copy
                    if (fd_in_use[tgt]) free_fd(int'(tgt));
                    take_fd(int'(tgt), fd_handle[fd]);
                    a.fd = tgt;
                end
            end
            OP_GET: begin
                if (!in_window(int'(fd)) || !fd_in_use[fd]) a.status = ST_BADF;
                else a.handle = fd_handle[fd];
            end
            OP_ISOPEN: begin
                a.is_open = in_window(int'(fd)) && fd_in_use[fd];
            end
            default: begin
                a.status = ST_INVAL;
            end
        endcase
        a.total = TOTAL_W'(shadow_open);
        return a;
    endfunction

    // Track config, predict on each accepted request, compare each accepted result
    always @(posedge aclk) begin
        table_answer_t want;
        int d;
        if (!aresetn) begin
            for (d = 0; d < DESCRIPTORS; d++) begin
                fd_in_use[d] = 1'b0;
                fd_handle[d] = '0;
            end
            shadow_open = 0;
            low_fd      = int'(LOW_FD_RESET);
            next_hint   = int'(LOW_FD_RESET);
            answers_due.delete();
        end else begin
            if (cfg_wen) low_fd = int'(cfg_wdata);
            if (s_valid && s_ready) begin
                answers_due.push_back(predict_table_op(s_operation, s_fd, s_target_fd,
                                                       s_file_handle));
            end
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Result with no request outstanding: status %0d fd %0d",
                                 m_status, m_result_fd);
                end else begin
                    want = answers_due.pop_front();
                    checked++;
                    if (m_status !== want.status || m_result_fd !== want.fd ||
                        m_handle_out !== want.handle || m_is_open !== want.is_open ||
                        m_open_total !== want.total) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("Result %0d mismatch:", checked);
                            $display("    expected status %0d fd %0d handle %h open %0b total %0d",
                                     want.status, want.fd, want.handle, want.is_open,
                                     want.total);
                            $display("    got status %0d fd %0d handle %h open %0b total %0d",
                                     m_status, m_result_fd, m_handle_out, m_is_open,
                                     m_open_total);
                        end
                    end
                end
            end
        end
        pending = answers_due.size();
    end

endmodule

// ===== dv/descriptor_table_allocator_test.sv =====
// Top of the descriptor table allocator testbench: clock, reset, stimulus, verdict.
// Depends on dta_pkg, descriptor_table_allocator and descriptor_table_checker.
`timescale 1ns / 1ps

module descriptor_table_allocator_test
    import dta_pkg::*;
();

    localparam int DESCRIPTORS  = 1024;
    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 40;

    // Operation codes the block does not define
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

    typedef enum int {MIX_GENERAL, MIX_FILL, MIX_DRAIN} mix_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_wen       = 1'b0;
    logic [FD_W-1:0]     cfg_wdata     = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation   = '0;
    logic [FD_W-1:0]     s_fd          = '0;
    logic [FD_W-1:0]     s_target_fd   = '0;
    logic [HANDLE_W-1:0] s_file_handle = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [FD_W-1:0]     m_result_fd;
    logic [HANDLE_W-1:0] m_handle_out;
    logic                m_is_open;
    logic [TOTAL_W-1:0]  m_open_total;

    int fail_count;
    int pending;
    int checked;
    int sent        = 0;
    int settings    = 0;
    int cycle_count = 0;
    int lowest_fd   = int'(LOW_FD_RESET);
    bit calm        = 1'b0;

    descriptor_table_allocator #(
        .DESCRIPTORS (DESCRIPTORS),
        .HANDLE_BITS (HANDLE_W)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_fd          (s_fd),
        .s_target_fd   (s_target_fd),
        .s_file_handle (s_file_handle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_result_fd   (m_result_fd),
        .m_handle_out  (m_handle_out),
        .m_is_open     (m_is_open),
        .m_open_total  (m_open_total)
    );

    descriptor_table_checker #(
        .DESCRIPTORS (DESCRIPTORS)
    ) table_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_fd          (s_fd),
        .s_target_fd   (s_target_fd),
        .s_file_handle (s_file_handle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_result_fd   (m_result_fd),
        .m_handle_out  (m_handle_out),
        .m_is_open     (m_is_open),
        .m_open_total  (m_open_total),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    always #4 aclk = ~aclk;

    // Stall the result side at random, except during the calm stretch
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("descriptor_table_allocator regression: fail");
            $finish;
        end
    end

    // Present one request after an optional random gap; return at the
    // falling edge after it is accepted
    task automatic send_request(input logic [OP_W-1:0] op, input logic [FD_W-1:0] fd,
                                input logic [FD_W-1:0] tgt,
                                input logic [HANDLE_W-1:0] fh);
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_fd          <= fd;
        s_target_fd   <= tgt;
        s_file_handle <= fh;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    // Drop valid, wait for the table to go idle, then write lowest_usable_fd
    task automatic set_lowest_fd(input logic [FD_W-1:0] value);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        cfg_wdata <= value;
        cfg_wen   <= 1'b1;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        lowest_fd = int'(value);
        settings++;
    endtask

    // Favor descriptors just above the lowest usable one, where allocation lands
    function automatic logic [FD_W-1:0] pick_fd(input bit near_only);
        int r;
        int span;
        r = $urandom_range(0, 99);
        span = (DESCRIPTORS - 1 - lowest_fd < 47) ? DESCRIPTORS - 1 - lowest_fd : 47;
        if (near_only || r < 70) return FD_W'(lowest_fd + $urandom_range(0, span));
        if (r < 80 && lowest_fd > 0) return FD_W'($urandom_range(0, lowest_fd - 1));
        return FD_W'($urandom_range(0, DESCRIPTORS - 1));
    endfunction

    task automatic random_request(input mix_t mix);
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] fh;
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                op = (r < 82) ? OP_ALLOC : (r < 96) ? OP_DUP : (r < 98) ? OP_GET : OP_ISOPEN;
            end
            MIX_DRAIN: begin
                op = (r < 45) ? OP_CLOSE : (r < 60) ? OP_ALLOC : (r < 70) ? OP_DUP :
                     (r < 80) ? OP_DUP2 : (r < 90) ? OP_GET : OP_ISOPEN;
            end
            default: begin
                op = (r < 30) ? OP_ALLOC : (r < 50) ? OP_CLOSE : (r < 65) ? OP_DUP :
                     (r < 77) ? OP_DUP2 : (r < 87) ? OP_GET : (r < 96) ? OP_ISOPEN :
                     ($urandom_range(0, 1) ? OP_RESERVED_HI : OP_RESERVED_LO);
            end
        endcase
        if (mix != MIX_FILL && $urandom_range(0, 99) < 4) fh = '0;
        else fh = HANDLE_W'($urandom_range(1, 65535));
        send_request(op, pick_fd(mix == MIX_FILL), pick_fd(1'b0), fh);
    endtask

    task automatic random_phase(input logic [FD_W-1:0] low, input mix_t mix,
                                input int count, input int calm_count);
        set_lowest_fd(low);
        for (int n = 0; n < count; n++) begin
            calm = (n < calm_count);
            random_request(mix);
        end
        calm = 1'b0;
    endtask

    initial begin
        int directed;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset setting, lowest usable fd is 3
        send_request(OP_ISOPEN, 10'd0, 10'd0, 16'h0000);     // below the window
        send_request(OP_GET, 10'd5, 10'd0, 16'h0001);        // never opened
        send_request(OP_CLOSE, 10'd5, 10'd0, 16'h0001);      // close of a free fd
        send_request(OP_ALLOC, 10'd0, 10'd0, 16'h0000);      // alloc without a handle
        send_request(OP_ALLOC, 10'd0, 10'd0, 16'hFFFF);
        send_request(OP_ALLOC, 10'd1023, 10'd1023, 16'h0001);
        send_request(OP_ALLOC, 10'd0, 10'd0, 16'h8000);
        send_request(OP_GET, 10'd3, 10'd0, 16'h0000);
        send_request(OP_ISOPEN, 10'd4, 10'd0, 16'h0000);
        send_request(OP_DUP, 10'd3, 10'd0, 16'h0000);
        send_request(OP_DUP2, 10'd3, 10'd3, 16'h0000);       // dup2 onto itself
        send_request(OP_DUP2, 10'd3, 10'd1023, 16'h0000);
        send_request(OP_DUP2, 10'd4, 10'd1023, 16'h0000);    // replace an open target
        send_request(OP_DUP2, 10'd1023, 10'd0, 16'h0000);    // target below the window
        send_request(OP_DUP2, 10'd7, 10'd8, 16'h0000);       // source not open
        send_request(OP_DUP, 10'd1023, 10'd0, 16'h0000);
        send_request(OP_CLOSE, 10'd4, 10'd0, 16'h0000);      // pull the hint down
        send_request(OP_DUP, 10'd5, 10'd0, 16'h0000);
        send_request(OP_RESERVED_LO, 10'd3, 10'd3, 16'h1234);
        send_request(OP_RESERVED_HI, 10'd1023, 10'd1023, 16'hFFFF);
        send_request(OP_ISOPEN, 10'd1023, 10'd0, 16'h0000);
        send_request(OP_GET, 10'd1023, 10'd1023, 16'h0000);
        send_request(OP_CLOSE, 10'd1023, 10'd0, 16'h0000);
        send_request(OP_DUP, 10'd2, 10'd0, 16'h0000);        // source below the window
        directed = sent;

        // Random phases over several settings of the lowest usable fd
        random_phase(10'd1023, MIX_GENERAL, 60, 0);
        random_phase(10'd1000, MIX_GENERAL, 80, 0);
        random_phase(10'd448, MIX_FILL, 640, 300);
        random_phase(FD_W'($urandom_range(1, 999)), MIX_DRAIN, 100, 0);
        random_phase(LOW_FD_RESET, MIX_GENERAL, 60, 0);

        // Drain outstanding results, then let the block settle
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d requests (%0d directed) over %0d table settings,",
                 sent, directed, settings);
        $display("%0d results checked, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("descriptor_table_allocator regression: pass");
        end else begin
            $display("descriptor_table_allocator regression: fail");
        end
        $finish;
    end

endmodule
